### hw/rtl/diff_drive_odometry_unit_defines.svh
// Assertion helpers for the checker file.
`ifndef DIFF_DRIVE_ODOMETRY_UNIT_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define DDO_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ddo check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is low.
`define DDO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ddo check failed: next-cycle rule");

`endif

### hw/rtl/ddo_pkg.sv
package ddo_pkg;

    // Default configuration of the block
    localparam int DEFAULT_CORDIC_STEPS = 16;
    localparam int DEFAULT_POS_BITS     = 32;

    // Heading gain register
    localparam int GAIN_W = 24;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd149325;

    // Angle and CORDIC datapath
    localparam int ANG_W        = 32;
    localparam int FRAC_BITS    = 30;
    localparam logic signed [ANG_W-1:0] CORDIC_K = 32'sd652032875;
    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);

    // Step distance: |(vr+vl)*dt| / (2*1000). Since 2000 = 16 * 125, the magnitude is
    // shifted down by 4 and divided by 125 with a reciprocal multiply, exact for any
    // 28-bit operand.
    localparam int DIVISOR    = 2 * 1000;
    localparam int NUM_W      = 32;
    localparam int DIV_PRE_SH = 4;
    localparam int QUO_W      = 22;
    localparam int RECIP_SH   = 35;
    localparam int RECIP_W    = 29;
    localparam logic [RECIP_W-1:0] RECIP_125 = 29'd274877907;  // ceil(2^35 / 125)
    localparam int D_W        = QUO_W + 1;

    // Controls of the CORDIC unit
    typedef struct packed {
        logic load;
        logic step;
    } ddo_cordic_ctl_t;

    // Arctangent of 2^-i in binary angle units, rounded to nearest
    function automatic logic [ANG_W-1:0] atan_bam(input logic [ATAN_IDX_W-1:0] idx);
        logic [ANG_W-1:0] val;
        begin
            case (idx)
                5'd0:    val = 32'h2000_0000;
                5'd1:    val = 32'h12E4_051E;
                5'd2:    val = 32'h09FB_385B;
                5'd3:    val = 32'h0511_11D4;
                5'd4:    val = 32'h028B_0D43;
                5'd5:    val = 32'h0145_D7E1;
                5'd6:    val = 32'h00A2_F61E;
                5'd7:    val = 32'h0051_7C55;
                5'd8:    val = 32'h0028_BE53;
                5'd9:    val = 32'h0014_5F2F;
                5'd10:   val = 32'h000A_2F98;
                5'd11:   val = 32'h0005_17CC;
                5'd12:   val = 32'h0002_8BE6;
                5'd13:   val = 32'h0001_45F3;
                5'd14:   val = 32'h0000_A2FA;
                5'd15:   val = 32'h0000_517D;
                5'd16:   val = 32'h0000_28BE;
                5'd17:   val = 32'h0000_145F;
                5'd18:   val = 32'h0000_0A30;
                5'd19:   val = 32'h0000_0518;
                5'd20:   val = 32'h0000_028C;
                5'd21:   val = 32'h0000_0146;
                5'd22:   val = 32'h0000_00A3;
                5'd23:   val = 32'h0000_0051;
                default: val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

### hw/rtl/ddo_ifs.sv
// Wheel sample channel
interface ddo_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] right_wheel_speed;
    logic signed [15:0] left_wheel_speed;
    logic        [15:0] dt_us;

    modport source (output valid, output right_wheel_speed, output left_wheel_speed,
                    output dt_us, input ready);
    modport sink   (input valid, input right_wheel_speed, input left_wheel_speed,
                    input dt_us, output ready);
endinterface

// Pose result channel
interface ddo_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x_um;
    logic signed [31:0] pos_z_um;
    logic        [31:0] heading_angle;
    logic signed [31:0] step_distance_um;

    modport source (output valid, output pos_x_um, output pos_z_um, output heading_angle,
                    output step_distance_um, input ready);
    modport sink   (input valid, input pos_x_um, input pos_z_um, input heading_angle,
                    input step_distance_um, output ready);
endinterface

// Heading gain write channel
interface ddo_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] heading_gain;

    modport source (output valid, output heading_gain, input ready);
    modport sink   (input valid, input heading_gain, output ready);
endinterface

### hw/rtl/ddo_cordic.sv
module ddo_cordic #(
    parameter int IDX_W = 5
) (
    input  logic                              clk,
    input  ddo_pkg::ddo_cordic_ctl_t          ctl,
    input  logic [IDX_W-1:0]                  idx,
    input  logic [ddo_pkg::ANG_W-1:0]         angle,
    output logic signed [ddo_pkg::ANG_W-1:0]  sin_val,
    output logic signed [ddo_pkg::ANG_W-1:0]  cos_val
);
    import ddo_pkg::*;

    logic signed [ANG_W-1:0] x_reg;
    logic signed [ANG_W-1:0] y_reg;
    logic signed [ANG_W-1:0] z_reg;
    logic                    flip_reg;

    logic                    flip_in;
    logic signed [ANG_W-1:0] xs;
    logic signed [ANG_W-1:0] ys;
    logic signed [ANG_W-1:0] atan_val;

    // Quadrants 01 and 10 are turned by half a turn and negated at the end
    assign flip_in = angle[ANG_W-1] ^ angle[ANG_W-2];

    // Shared shifter and table lookup for the current iteration
    assign xs       = x_reg >>> idx;
    assign ys       = y_reg >>> idx;
    assign atan_val = $signed(atan_bam(ATAN_IDX_W'(idx)));

    // Rotation-mode iteration registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            flip_reg <= flip_in;
            x_reg    <= CORDIC_K;
            y_reg    <= '0;
            z_reg    <= $signed(angle ^ {flip_in, {(ANG_W-1){1'b0}}});
        end
        else if (ctl.step)
        begin
            if (!z_reg[ANG_W-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_val;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_val;
            end
        end
    end

    // Undo the half turn
    assign sin_val = flip_reg ? -y_reg : y_reg;
    assign cos_val = flip_reg ? -x_reg : x_reg;

endmodule

### hw/rtl/diff_drive_odometry_unit.sv
// Differential-drive odometry. Each wheel sample (right and left speed in mm/s, elapsed
// time in us) moves the pose: the step distance d = (vr+vl)*dt/2000 um, truncated toward
// zero, is projected with sin and cos of the heading held before the step and added to
// x and z (saturating at the signed POS_BITS range), then the turn
// ((vr-vl)*dt*heading_gain)>>16 is added to the wrapping 32-bit heading. One sample is
// taken at a time: after it is accepted, the block forms the products, runs the CORDIC
// iteration loop, forms the projections, updates the pose and heading and loads the
// result, and the next sample can be accepted in the same cycle as the result appears.
// The divide by 2000 is a reciprocal multiply done in the first loop cycle, and one
// shared multiplier forms the two projections afterwards. A finished result waits in
// the output register while the next sample is taken; if the previous result has still
// not been taken when the next one is done, the block holds in its last state until it
// is. The heading gain is written through the configuration channel, which is always
// ready.
module diff_drive_odometry_unit #(
    parameter int CORDIC_STEPS = ddo_pkg::DEFAULT_CORDIC_STEPS,
    parameter int POS_BITS     = ddo_pkg::DEFAULT_POS_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    ddo_sample_if.sink    sample,
    ddo_result_if.source  result,
    ddo_cfg_if.sink       cfg
);
    import ddo_pkg::*;

    localparam int LOOP_STEPS = CORDIC_STEPS;
    localparam int CNT_W      = $clog2(LOOP_STEPS);
    localparam int PRE_W      = 34;
    localparam int TURN_W     = PRE_W + GAIN_W + 1;
    localparam int MAG_W      = NUM_W - DIV_PRE_SH;
    localparam int RPROD_W    = MAG_W + RECIP_W;
    localparam int PROD_W     = D_W + ANG_W;
    localparam int INC_W      = PROD_W + 1 - FRAC_BITS;
    localparam int SUM_W      = ((POS_BITS > INC_W) ? POS_BITS : INC_W) + 1;
    localparam logic signed [SUM_W-1:0] POS_MAX =
        SUM_W'((64'sd1 <<< (POS_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] POS_MIN = -POS_MAX - SUM_W'(1);
    localparam logic signed [PROD_W:0] ROUND_HALF = (PROD_W+1)'(64'sd1 <<< (FRAC_BITS - 1));

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_ITER = 3'd3;
    localparam logic [2:0] ST_PX   = 3'd4;
    localparam logic [2:0] ST_PZ   = 3'd5;
    localparam logic [2:0] ST_UPD  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    // Control and state registers
    logic [2:0]                 state_reg, state_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [GAIN_W-1:0]          gain_reg, gain_next;
    logic signed [POS_BITS-1:0] pose_x_reg, pose_x_next;
    logic signed [POS_BITS-1:0] pose_z_reg, pose_z_next;
    logic [ANG_W-1:0]           heading_reg, heading_next;
    logic                       res_valid_reg, res_valid_next;

    // Datapath registers
    logic signed [15:0]         vr_reg;
    logic signed [15:0]         vl_reg;
    logic        [15:0]         dt_reg;
    logic signed [PRE_W-1:0]    sumdt_reg;
    logic signed [PRE_W-1:0]    diffdt_reg;
    logic [ANG_W-1:0]           dyaw_reg;
    logic [MAG_W-1:0]           num_reg;
    logic [QUO_W-1:0]           quo_reg;
    logic                       neg_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [31:0]         out_x_reg;
    logic signed [31:0]         out_z_reg;
    logic [31:0]                out_h_reg;
    logic signed [31:0]         out_d_reg;

    // Combinational signals
    logic                       in_take;
    logic                       out_load;
    logic                       last_iter;
    logic signed [16:0]         sum17;
    logic signed [16:0]         diff17;
    logic signed [16:0]         dt17;
    logic signed [PRE_W-1:0]    sumdt_full;
    logic signed [PRE_W-1:0]    diffdt_full;
    logic signed [TURN_W-1:0]   turn_full;
    logic signed [PRE_W-1:0]    sumdt_mag;
    logic [RPROD_W-1:0]         recip_prod;
    logic signed [D_W-1:0]      d_val;
    logic signed [ANG_W-1:0]    sin_val;
    logic signed [ANG_W-1:0]    cos_val;
    logic signed [ANG_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]   prod_full;
    logic signed [PROD_W:0]     rnd_sum;
    logic signed [INC_W-1:0]    inc_val;
    ddo_cordic_ctl_t            cordic_ctl;

    // Add an increment to a position and clamp it
    function automatic logic signed [POS_BITS-1:0] sat_add(
        input logic signed [POS_BITS-1:0] pos,
        input logic signed [INC_W-1:0]    inc
    );
        logic signed [SUM_W-1:0] total;
        begin
            total = SUM_W'(pos) + SUM_W'(inc);
            if (total > POS_MAX)
                total = POS_MAX;
            else if (total < POS_MIN)
                total = POS_MIN;
            return POS_BITS'(total);
        end
    endfunction

    // Handshakes
    assign sample.ready = (state_reg == ST_IDLE);
    assign in_take      = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;
    assign out_load     = (state_reg == ST_OUT) && (!res_valid_reg || result.ready);
    assign last_iter    = (cnt_reg == CNT_W'(LOOP_STEPS - 1));

    // Speed sum and difference times elapsed time
    assign sum17       = 17'(vr_reg) + 17'(vl_reg);
    assign diff17      = 17'(vr_reg) - 17'(vl_reg);
    assign dt17        = $signed({1'b0, dt_reg});
    assign sumdt_full  = sum17 * dt17;
    assign diffdt_full = diff17 * dt17;

    // Turn in binary angle units
    assign turn_full = diffdt_reg * $signed({1'b0, gain_reg});

    // Distance magnitude over 2000: shift by 4, then reciprocal multiply for 125
    assign sumdt_mag  = sumdt_reg[PRE_W-1] ? -sumdt_reg : sumdt_reg;
    assign recip_prod = num_reg * RECIP_125;
    assign d_val      = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    // Shared projection multiplier and rounding
    assign mul_b     = (state_reg == ST_PX) ? sin_val : cos_val;
    assign prod_full = d_val * mul_b;
    assign rnd_sum   = (PROD_W+1)'(prod_reg) + ROUND_HALF;
    assign inc_val   = rnd_sum[PROD_W:FRAC_BITS];

    // CORDIC control
    assign cordic_ctl.load = in_take;
    assign cordic_ctl.step = (state_reg == ST_ITER);

    ddo_cordic #(
        .IDX_W (CNT_W)
    ) u_cordic (
        .clk     (clk),
        .ctl     (cordic_ctl),
        .idx     (cnt_reg),
        .angle   (heading_reg),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    // Sequencer and state update
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        gain_next      = gain_reg;
        pose_x_next    = pose_x_reg;
        pose_z_next    = pose_z_reg;
        heading_next   = heading_reg;
        res_valid_next = res_valid_reg;

        if (cfg.valid && cfg.ready)
            gain_next = cfg.heading_gain;

        if (res_valid_reg && result.ready)
            res_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cnt_next   = '0;
                state_next = ST_ITER;
            end
            ST_ITER:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_iter)
                    state_next = ST_PX;
            end
            ST_PX:
            begin
                state_next = ST_PZ;
            end
            ST_PZ:
            begin
                pose_x_next = sat_add(pose_x_reg, inc_val);
                state_next  = ST_UPD;
            end
            ST_UPD:
            begin
                pose_z_next  = sat_add(pose_z_reg, inc_val);
                heading_next = heading_reg + dyaw_reg;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Registers with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            gain_reg      <= GAIN_RESET;
            pose_x_reg    <= '0;
            pose_z_reg    <= '0;
            heading_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            gain_reg      <= gain_next;
            pose_x_reg    <= pose_x_next;
            pose_z_reg    <= pose_z_next;
            heading_reg   <= heading_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            vr_reg <= sample.right_wheel_speed;
            vl_reg <= sample.left_wheel_speed;
            dt_reg <= sample.dt_us;
        end

        if (state_reg == ST_MUL)
        begin
            sumdt_reg  <= sumdt_full;
            diffdt_reg <= diffdt_full;
        end

        if (state_reg == ST_PREP)
        begin
            dyaw_reg <= turn_full[ANG_W+15:16];
            neg_reg  <= sumdt_reg[PRE_W-1];
            num_reg  <= sumdt_mag[NUM_W-1:DIV_PRE_SH];
        end

        // quotient is ready from the second loop cycle on
        if ((state_reg == ST_ITER) && (cnt_reg == '0))
            quo_reg <= recip_prod[RECIP_SH+QUO_W-1:RECIP_SH];

        if ((state_reg == ST_PX) || (state_reg == ST_PZ))
            prod_reg <= prod_full;

        if (out_load)
        begin
            out_x_reg <= 32'(pose_x_reg);
            out_z_reg <= 32'(pose_z_reg);
            out_h_reg <= heading_reg;
            out_d_reg <= 32'(d_val);
        end
    end

    // Result channel
    assign result.valid            = res_valid_reg;
    assign result.pos_x_um         = out_x_reg;
    assign result.pos_z_um         = out_z_reg;
    assign result.heading_angle    = out_h_reg;
    assign result.step_distance_um = out_d_reg;

endmodule

### hw/rtl/ddo_checker.sv
`include "diff_drive_odometry_unit_defines.svh"

module ddo_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_valid,
    input logic        s_ready,
    input logic        r_valid,
    input logic        r_ready,
    input logic [31:0] r_pos_x,
    input logic [31:0] r_pos_z,
    input logic [31:0] r_heading,
    input logic [31:0] r_dist
);

    // Busy after a request: no second request in the next cycle
    `DDO_ASSERT_NEXT(a_busy_after_req, clk, rst_n, s_valid && s_ready, !s_ready)

    // A result never shows up right after its request
    `DDO_ASSERT_NEXT(a_min_latency, clk, rst_n, s_valid && s_ready, !$rose(r_valid))

    // A new result is loaded only while the input side is busy
    `DDO_ASSERT_SAME(a_result_from_busy, clk, rst_n, $rose(r_valid), $past(!s_ready))

    // A stalled result holds
    `DDO_ASSERT_NEXT(a_result_hold, clk, rst_n, r_valid && !r_ready,
                     r_valid && $stable(r_pos_x) && $stable(r_pos_z) &&
                     $stable(r_heading) && $stable(r_dist))

endmodule

bind diff_drive_odometry_unit ddo_checker u_ddo_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_valid   (sample.valid),
    .s_ready   (sample.ready),
    .r_valid   (result.valid),
    .r_ready   (result.ready),
    .r_pos_x   (result.pos_x_um),
    .r_pos_z   (result.pos_z_um),
    .r_heading (result.heading_angle),
    .r_dist    (result.step_distance_um)
);
